/* rtl/core/ordered_list_append_delete_core_assert.svh */
// assertion macros shared by the ordered list core modules
`ifndef ORDERED_LIST_APPEND_DELETE_CORE_ASSERT_SVH
`define ORDERED_LIST_APPEND_DELETE_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define OLAD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("olad assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define OLAD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("olad assertion failed");

`endif

/* rtl/core/olad_pkg.sv */
// shared types and constants for the ordered list core
`default_nettype none

package olad_pkg;

    localparam int LIST_DEPTH = 32;
    localparam int ADDR_W     = $clog2(LIST_DEPTH);
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_DUMP   = 2'd2;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] entry_value;
        logic               list_empty;
        logic               overflow_seen;
        logic               last_of_dump;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic append;      // append value at tail, or flag overflow when full
        logic load_value;  // capture the search value
        logic idx_clr;
        logic idx_inc;
        logic rd_en;       // read entry at idx (or idx+1) into read register
        logic rd_plus1;
        logic shift_wr;    // write read register into entry idx
        logic count_dec;
        logic out_load;    // load a dump result into the output register
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic cnt_zero;
        logic idx_last;    // idx + 1 >= count
        logic match;       // read register equals search value
        logic out_free;    // output register can take a new result this cycle
    } dp_status_t;

endpackage

`default_nettype wire

/* rtl/core/olad_datapath.sv */
// list store, count, overflow flag, index and output register
`default_nettype none
`include "ordered_list_append_delete_core_assert.svh"

module olad_datapath (
    input  wire                  clk,
    input  wire                  rst_n,
    input  olad_pkg::dp_cmd_t    cmd,
    output olad_pkg::dp_status_t status,
    input  wire signed [31:0]    value,
    output logic                 out_valid,
    input  wire                  out_ready,
    output olad_pkg::out_item_t  out_data
);
    import olad_pkg::*;

    logic signed [31:0] mem [LIST_DEPTH];
    logic signed [31:0] rd_reg;
    logic signed [31:0] value_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               overflow_reg;
    logic               overflow_next;
    logic [ADDR_W-1:0]  idx_reg;
    logic [ADDR_W-1:0]  idx_next;
    logic [ADDR_W-1:0]  idx_plus1;
    logic [ADDR_W-1:0]  rd_addr;
    logic               out_valid_reg;
    logic               out_valid_next;
    out_item_t          out_reg;
    logic               full;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic signed [31:0] wr_data;

    assign full      = (count_reg == CNT_W'(LIST_DEPTH));
    assign idx_plus1 = idx_reg + ADDR_W'(1);
    assign rd_addr   = cmd.rd_plus1 ? idx_plus1 : idx_reg;

    assign status.cnt_zero = (count_reg == '0);
    assign status.idx_last = ((CNT_W'(idx_reg) + CNT_W'(1)) >= count_reg);
    assign status.match    = (rd_reg == value_reg);
    assign status.out_free = !out_valid_reg || out_ready;

    // append writes at the tail, a shift writes one place toward the head
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = idx_reg;
        wr_data = rd_reg;
        if (cmd.append && !full)
        begin
            wr_en   = 1'b1;
            wr_addr = ADDR_W'(count_reg);
            wr_data = value;
        end
        else if (cmd.shift_wr)
        begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_reg <= mem[rd_addr];
        end
        if (cmd.load_value)
        begin
            value_reg <= value;
        end
        if (cmd.out_load)
        begin
            out_reg.entry_value   <= status.cnt_zero ? '0 : rd_reg;
            out_reg.list_empty    <= status.cnt_zero;
            out_reg.overflow_seen <= overflow_reg;
            out_reg.last_of_dump  <= status.cnt_zero || status.idx_last;
        end
    end

    always_comb
    begin
        count_next    = count_reg;
        overflow_next = overflow_reg;
        if (cmd.append)
        begin
            if (full)
            begin
                overflow_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
        else if (cmd.count_dec)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.idx_clr)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_plus1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            overflow_reg  <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            overflow_reg  <= overflow_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `OLAD_ASSERT_NEXT(a_overflow_sticky, overflow_reg, overflow_reg)
    `OLAD_ASSERT_NEXT(a_full_append_drops, cmd.append && full,
                      overflow_reg && $stable(count_reg))
    `OLAD_ASSERT_NOW(a_count_bounded, cmd.append || cmd.count_dec,
                     count_reg <= CNT_W'(LIST_DEPTH))

endmodule

`default_nettype wire

/* rtl/core/olad_ctrl.sv */
// command sequencer for append, delete search and shift, and dump
`default_nettype none
`include "ordered_list_append_delete_core_assert.svh"

module olad_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  wire [1:0]            command,
    output olad_pkg::dp_cmd_t    cmd,
    input  olad_pkg::dp_status_t status
);
    import olad_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_DUMP_RD,
        S_DUMP_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (command)
                        CMD_APPEND:
                        begin
                            cmd.append = 1'b1;
                        end
                        CMD_DELETE:
                        begin
                            cmd.load_value = 1'b1;
                            cmd.idx_clr    = 1'b1;
                            state_next     = status.cnt_zero ? S_IDLE : S_SRCH_RD;
                        end
                        CMD_DUMP:
                        begin
                            cmd.idx_clr = 1'b1;
                            state_next  = status.cnt_zero ? S_DUMP_OUT : S_DUMP_RD;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SRCH_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_SRCH_CMP;
            end
            S_SRCH_CMP:
            begin
                if (status.match)
                begin
                    state_next = S_SHIFT_RD;
                end
                else if (status.idx_last)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_SRCH_RD;
                end
            end
            S_SHIFT_RD:
            begin
                if (status.idx_last)
                begin
                    cmd.count_dec = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    cmd.rd_en    = 1'b1;
                    cmd.rd_plus1 = 1'b1;
                    state_next   = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR:
            begin
                cmd.shift_wr = 1'b1;
                cmd.idx_inc  = 1'b1;
                state_next   = S_SHIFT_RD;
            end
            S_DUMP_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_DUMP_OUT;
            end
            S_DUMP_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (status.cnt_zero || status.idx_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_DUMP_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `OLAD_ASSERT_NOW(a_load_only_when_free, cmd.out_load, status.out_free)
    `OLAD_ASSERT_NOW(a_no_read_of_empty, cmd.rd_en, !status.cnt_zero)
    `OLAD_ASSERT_NEXT(a_dec_ends_delete, cmd.count_dec, state_reg == S_IDLE)

endmodule

`default_nettype wire

/* rtl/core/ordered_list_append_delete_core.sv */
// top level of the ordered list core: append, delete first match, dump
//
// channels: in (in_valid/in_ready/in_data) carries one command and value per
//   transfer; out (out_valid/out_ready/out_data) carries dump results
// append and unknown commands finish in the accepting cycle and give no result
// delete reads and compares one entry at a time from the head, a read state
//   then a compare state per entry; on a hit it moves each later entry one place
//   toward the head with a read state and a write state per entry, then lowers
//   the entry count
// dump reads one entry and loads it into the output register once that register
//   is free, then reads the next, so it holds while the output register stays full;
//   an empty list gives one result with list_empty and last_of_dump set
// in_ready is high only between commands; after the last dump result is
//   loaded a new command is taken while that result still waits in out_data
// when the receiver stalls the dump holds in place, nothing is lost or repeated
// reset clears the entry count, the sticky overflow flag and out_valid; the
//   store itself is not cleared, entries past the count are never read
`default_nettype none

module ordered_list_append_delete_core (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  olad_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  wire                 out_ready,
    output olad_pkg::out_item_t out_data
);
    import olad_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    // sequencer: decodes each transfer and walks the store
    olad_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .command  (in_data.command),
        .cmd      (dp_cmd),
        .status   (dp_status)
    );

    // store, count, overflow flag and output register
    olad_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (dp_cmd),
        .status    (dp_status),
        .value     (in_data.value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
